>>> rtl/blr_pkg.sv
// Shared types and constants of the line rasterizer.
`default_nettype none
package blr_pkg;

   // Default grid size and command queue depth.
   localparam int GRID_WIDTH_DEF  = 60;
   localparam int GRID_HEIGHT_DEF = 60;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Field widths fixed by the stream formats.
   localparam int COORD_W    = 6;
   localparam int COL_W      = 6;
   localparam int ADDR_W     = 12;
   localparam int CHAN_W     = 8;
   localparam int COLOUR_W   = 3 * CHAN_W;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // Internal widths: grid positions may run off the grid by a full line.
   localparam int POS_W = 9;
   localparam int D_W   = 9;
   localparam int LEN_W = 6;

   // Line pixels per command beyond this count are dropped.
   localparam int LINE_LIMIT = 60;
   localparam int CNT_W      = $clog2(LINE_LIMIT + 1);

   // Colour of the closing end pixel.
   localparam logic [CHAN_W-1:0] END_RED   = 8'd0;
   localparam logic [CHAN_W-1:0] END_GREEN = 8'd255;
   localparam logic [CHAN_W-1:0] END_BLUE  = 8'd0;

   // One classified line command, folded into the first octant.
   typedef struct packed {
      logic signed [POS_W-1:0] start_col;
      logic signed [POS_W-1:0] start_row;
      logic signed [POS_W-1:0] end_col;
      logic signed [POS_W-1:0] end_row;
      logic [COLOUR_W-1:0]     colour;
      logic                    mir_x;
      logic                    mir_y;
      logic                    swap;
      logic [LEN_W-1:0]        major_len;
      logic signed [D_W-1:0]   d_init;
      logic signed [D_W-1:0]   inc_flat;
      logic signed [D_W-1:0]   inc_diag;
   } line_desc_type;

   // Queue status seen by the stepping engine.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage
`default_nettype wire

>>> rtl/blr_front.sv
// Command front end: octant classification and Bresenham setup terms.
`default_nettype none
module blr_front #(
   parameter int GRID_WIDTH  = blr_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = blr_pkg::GRID_HEIGHT_DEF
) (
   input  wire logic signed [blr_pkg::COORD_W-1:0]  start_x,
   input  wire logic signed [blr_pkg::COORD_W-1:0]  start_y,
   input  wire logic signed [blr_pkg::COORD_W-1:0]  end_x,
   input  wire logic signed [blr_pkg::COORD_W-1:0]  end_y,
   input  wire logic [blr_pkg::COLOUR_W-1:0]        colour,
   output blr_pkg::line_desc_type                   desc
);
   import blr_pkg::*;

   localparam int HALF_W = GRID_WIDTH / 2;
   localparam int HALF_H = GRID_HEIGHT / 2;

   logic signed [COORD_W:0] dx;
   logic signed [COORD_W:0] dy;
   logic [LEN_W-1:0]        adx;
   logic [LEN_W-1:0]        ady;
   logic [LEN_W-1:0]        major;
   logic [LEN_W-1:0]        minor;
   logic                    swap;

   always_comb begin
      dx    = (COORD_W+1)'(end_x) - (COORD_W+1)'(start_x);
      dy    = (COORD_W+1)'(end_y) - (COORD_W+1)'(start_y);
      adx   = dx[COORD_W] ? LEN_W'(-dx) : LEN_W'(dx);
      ady   = dy[COORD_W] ? LEN_W'(-dy) : LEN_W'(dy);
      swap  = ady > adx;
      major = swap ? ady : adx;
      minor = swap ? adx : ady;

      desc.start_col = POS_W'(start_x) + $signed(POS_W'(HALF_W));
      desc.start_row = POS_W'(start_y) + $signed(POS_W'(HALF_H));
      desc.end_col   = POS_W'(end_x) + $signed(POS_W'(HALF_W));
      desc.end_row   = POS_W'(end_y) + $signed(POS_W'(HALF_H));
      desc.colour    = colour;
      desc.mir_x     = dx[COORD_W];
      desc.mir_y     = dy[COORD_W];
      desc.swap      = swap;
      desc.major_len = major;
      // 2*minor, 2*(minor-major) and 2*minor-major
      desc.inc_flat  = $signed(D_W'({minor, 1'b0}));
      desc.inc_diag  = $signed(D_W'({minor, 1'b0})) - $signed(D_W'({major, 1'b0}));
      desc.d_init    = $signed(D_W'({minor, 1'b0})) - $signed(D_W'(major));
   end

endmodule
`default_nettype wire

>>> rtl/blr_queue.sv
// Short command queue between front end and stepping engine.
`default_nettype none
module blr_queue #(
   parameter int DEPTH = blr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  blr_pkg::line_desc_type     push_data,
   input  wire logic                  pop,
   output blr_pkg::line_desc_type     pop_data,
   output blr_pkg::queue_status_type  status
);
   import blr_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   line_desc_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == COUNT_W'(DEPTH));
      pop_data     = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("queue fill count above depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue pushed while full");
`endif

endmodule
`default_nettype wire

>>> rtl/blr_back.sv
// Stepping engine: walks the line one pixel a cycle, while the receiver does not stall, into the output register.
`default_nettype none
module blr_back #(
   parameter int GRID_WIDTH  = blr_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = blr_pkg::GRID_HEIGHT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  blr_pkg::line_desc_type              q_data,
   input  blr_pkg::queue_status_type           q_status,
   output logic                                q_pop,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [blr_pkg::COL_W-1:0]           out_col,
   output logic [blr_pkg::COL_W-1:0]           out_row,
   output logic [blr_pkg::ADDR_W-1:0]          out_addr,
   output logic [blr_pkg::COLOUR_W-1:0]        out_colour,
   output logic                                out_last
);
   import blr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_START = 4'b0010,
      S_STEP  = 4'b0100,
      S_END   = 4'b1000
   } back_state_type;

   back_state_type          state_ff, state_in;
   line_desc_type           desc_ff, desc_in;
   logic signed [POS_W-1:0] col_ff, col_in;
   logic signed [POS_W-1:0] row_ff, row_in;
   logic signed [D_W-1:0]   d_ff, d_in;
   logic [LEN_W-1:0]        steps_ff, steps_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    out_valid_ff, out_valid_in;
   logic [COL_W-1:0]        out_col_ff;
   logic [COL_W-1:0]        out_row_ff;
   logic [ADDR_W-1:0]       out_addr_ff;
   logic [COLOUR_W-1:0]     out_colour_ff;
   logic                    out_last_ff;

   logic                    adv;
   logic                    attempt;
   logic                    keep;
   logic                    load_out;
   logic                    in_grid;
   logic                    take_minor;
   logic signed [D_W-1:0]   d_next;
   logic signed [POS_W-1:0] x_delta;
   logic signed [POS_W-1:0] y_delta;
   logic signed [POS_W-1:0] step_col;
   logic signed [POS_W-1:0] step_row;
   logic signed [POS_W-1:0] cand_col;
   logic signed [POS_W-1:0] cand_row;
   logic [COLOUR_W-1:0]     cand_colour;
   logic                    cand_last;
   logic [ADDR_W-1:0]       cand_addr;

   always_comb begin
      adv        = !out_valid_ff || out_ready;
      take_minor = !d_ff[D_W-1] && (d_ff != '0);
      d_next     = take_minor ? d_ff + desc_ff.inc_diag : d_ff + desc_ff.inc_flat;
      x_delta    = desc_ff.mir_x ? {POS_W{1'b1}} : POS_W'(1);
      y_delta    = desc_ff.mir_y ? {POS_W{1'b1}} : POS_W'(1);
      if (desc_ff.swap) begin
         step_col = take_minor ? x_delta : '0;
         step_row = y_delta;
      end else begin
         step_col = x_delta;
         step_row = take_minor ? y_delta : '0;
      end

      state_in    = state_ff;
      desc_in     = desc_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      d_in        = d_ff;
      steps_in    = steps_ff;
      count_in    = count_ff;
      q_pop       = 1'b0;
      attempt     = 1'b0;
      cand_col    = col_ff;
      cand_row    = row_ff;
      cand_colour = desc_ff.colour;
      cand_last   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            q_pop = !q_status.empty;
         end
         S_START: begin
            if (adv) begin
               attempt  = 1'b1;
               state_in = (steps_ff == '0) ? S_END : S_STEP;
            end
         end
         S_STEP: begin
            cand_col = col_ff + step_col;
            cand_row = row_ff + step_row;
            if (adv) begin
               attempt  = 1'b1;
               col_in   = cand_col;
               row_in   = cand_row;
               d_in     = d_next;
               steps_in = steps_ff - 1'b1;
               if (steps_ff == LEN_W'(1)) begin
                  state_in = S_END;
               end
            end
         end
         S_END: begin
            cand_col    = desc_ff.end_col;
            cand_row    = desc_ff.end_row;
            cand_colour = {END_BLUE, END_GREEN, END_RED};
            cand_last   = 1'b1;
            if (adv) begin
               attempt  = 1'b1;
               q_pop    = !q_status.empty;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      in_grid = !cand_col[POS_W-1] && (cand_col < $signed(POS_W'(GRID_WIDTH)))
             && !cand_row[POS_W-1] && (cand_row < $signed(POS_W'(GRID_HEIGHT)));
      keep      = in_grid && (cand_last || (count_ff < CNT_W'(LINE_LIMIT)));
      load_out  = attempt && keep;
      cand_addr = ADDR_W'(cand_col[COL_W-1:0])
                + ADDR_W'(GRID_WIDTH) * ADDR_W'(cand_row[COL_W-1:0]);

      if (load_out && !cand_last) begin
         count_in = count_ff + 1'b1;
      end

      // Load the next command into the walker.
      if (q_pop) begin
         state_in = S_START;
         desc_in  = q_data;
         col_in   = q_data.start_col;
         row_in   = q_data.start_row;
         d_in     = q_data.d_init;
         steps_in = q_data.major_len;
         count_in = '0;
      end

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff  <= desc_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      d_ff     <= d_in;
      steps_ff <= steps_in;
      count_ff <= count_in;
      if (load_out) begin
         out_col_ff    <= cand_col[COL_W-1:0];
         out_row_ff    <= cand_row[COL_W-1:0];
         out_addr_ff   <= cand_addr;
         out_colour_ff <= cand_colour;
         out_last_ff   <= cand_last;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_col    = out_col_ff;
   assign out_row    = out_row_ff;
   assign out_addr   = out_addr_ff;
   assign out_colour = out_colour_ff;
   assign out_last   = out_last_ff;

`ifndef ASSERT_OFF
   a_step_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP |-> steps_ff != '0)
      else $error("stepping with no steps left");
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> count_ff <= CNT_W'(LINE_LIMIT))
      else $error("line pixel count above limit");
   a_end_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END && adv) |=> state_ff != S_END)
      else $error("end pixel issued twice");
`endif

endmodule
`default_nettype wire

>>> rtl/bresenham_line_rasterizer_top.sv
// Top level of the Bresenham line rasterizer.
//
// Usage: each word on the req_ stream is one line command: two endpoints in
// grid-centred coordinates and a line colour. The block answers on the rsp_
// stream with pixel words: the start pixel, one pixel per major-axis step,
// then the end pixel again in fixed green with rsp_tlast high. Pixels off the
// grid are skipped, and at most 60 line-colored pixels go out per command.
// The start pixel passes from an accepted command through the command queue,
// the walker's start state and the output register to rsp_tvalid. Throughput:
// one pixel per cycle while rsp_tready is high; a command holds the walker for
// its start, step and end pixels. The front end classifies commands
// into a short queue, so new commands are taken while a line is drawn.
// Reset clears the queue, the walker state and rsp_tvalid; no clearing pass.
// When the receiver stalls, the output register holds its word, the walker
// waits, and req_tready drops only once the command queue is full.
`default_nettype none
module bresenham_line_rasterizer_top #(
   parameter int GRID_WIDTH  = blr_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = blr_pkg::GRID_HEIGHT_DEF,
   parameter int QUEUE_DEPTH = blr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18],
   // line_red[31:24], line_green[39:32], line_blue[47:40]
   input  wire logic [blr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // pixel_col[5:0], pixel_row[11:6], pixel_address[23:12],
   // pixel_red[31:24], pixel_green[39:32], pixel_blue[47:40]
   output logic [blr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast,   // final_pixel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready
);
   import blr_pkg::*;

   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;
   logic [COLOUR_W-1:0]       line_colour;
   line_desc_type             front_desc;
   line_desc_type             q_data;
   queue_status_type          q_status;
   logic                      q_push;
   logic                      q_pop;
   logic [COL_W-1:0]          pixel_col;
   logic [COL_W-1:0]          pixel_row;
   logic [ADDR_W-1:0]         pixel_address;
   logic [COLOUR_W-1:0]       pixel_colour;

   // Unpack the command word.
   assign start_x     = req_tdata[5:0];
   assign start_y     = req_tdata[11:6];
   assign end_x       = req_tdata[17:12];
   assign end_y       = req_tdata[23:18];
   assign line_colour = req_tdata[47:24];

   // Take a command whenever the queue has room.
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready;

   blr_front #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_front (
      .start_x (start_x),
      .start_y (start_y),
      .end_x   (end_x),
      .end_y   (end_y),
      .colour  (line_colour),
      .desc    (front_desc)
   );

   blr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_desc),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   blr_back #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_data     (q_data),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_col    (pixel_col),
      .out_row    (pixel_row),
      .out_addr   (pixel_address),
      .out_colour (pixel_colour),
      .out_last   (rsp_tlast)
   );

   // Pack the pixel word.
   assign rsp_tdata = {pixel_colour, pixel_address, pixel_row, pixel_col};

endmodule
`default_nettype wire
